FILE: rtl/tsp_nearest_neighbour_tour_macros.svh
// ----------------------------------------------------------------------------
// tsp_nearest_neighbour_tour_macros
// Assertion helpers for the tour builder; clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TSP_NEAREST_NEIGHBOUR_TOUR_MACROS_SVH
`define TSP_NEAREST_NEIGHBOUR_TOUR_MACROS_SVH

// same-cycle implication
`define TNN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tnn: same-cycle check failed");

// next-cycle implication
`define TNN_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tnn: next-cycle check failed");

`endif

FILE: rtl/tnn_pkg.sv
// ----------------------------------------------------------------------------
// tnn_pkg
// Shared widths, register indexes and the scan candidate type.
// ----------------------------------------------------------------------------
package tnn_pkg;

	localparam int CITY_W       = 4;
	localparam int POS_W        = 4;
	localparam int COUNT_W      = 5;
	localparam int COST_W       = 20;
	localparam int BEST_W       = 21;
	localparam int RESULT_LIMIT = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_STARTS = 2'd2;

	// one matrix entry under test in the compare unit
	typedef struct packed {
		logic              vld;
		logic              skip;   // city already visited
		logic [CITY_W-1:0] city;
	} cand_t;

endpackage

FILE: rtl/tnn_dist_mem.sv
// ----------------------------------------------------------------------------
// tnn_dist_mem
// Distance matrix store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tnn_dist_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/tnn_min_unit.sv
// ----------------------------------------------------------------------------
// tnn_min_unit
// Running minimum over one scan; strict compare keeps the lower city on ties.
// ----------------------------------------------------------------------------
module tnn_min_unit #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clr,
	input  tnn_pkg::cand_t               cand,
	input  logic [WEIGHT_BITS-1:0]       cand_dist,
	output logic [tnn_pkg::CITY_W-1:0]   best_city,
	output logic [WEIGHT_BITS-1:0]       best_dist
);

	logic found_q;
	logic take;

	assign take = cand.vld && !cand.skip && (!found_q || (cand_dist < best_dist));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clr) begin
			best_city <= cand.city;
			best_dist <= cand_dist;
		end
	end

endmodule

FILE: rtl/tsp_nearest_neighbour_tour.sv
// Sequence: a matrix beat is taken while idle. A beat with tlast and a valid
//   setup builds one trial tour per start (one start, or n when all starts are tried),
//   then loads the output register and emits n beats, one per cycle while the sink
//   is ready; intake reopens right after the last beat.
// Throughput: the single read port and the shared compare unit visit one
//   city per cycle; no new beat is taken until the tour is out.
// Reset: async, active low; registers to 16 cities, start 0, single mode.
// ----------------------------------------------------------------------------
// tsp_nearest_neighbour_tour
// Greedy nearest-neighbour tour over a loaded distance matrix, single start
// or best over all starts, emitted one city per beat with the closed cost.
// ----------------------------------------------------------------------------
module tsp_nearest_neighbour_tour #(
	parameter int MAX_CITIES  = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_wr_en,
	input  logic [tnn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tnn_pkg::CFG_DATA_W-1:0]     cfg_data,
	// matrix entries in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [23:0]                        s_axis_tdata,  // row[3:0] col[7:4] weight[23:8]
	input  logic                               s_axis_tlast,  // load_done
	// tour out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // position[3:0] city[7:4]
	                                                          // tour_cost[27:8], zero pad
	output logic                               m_axis_tlast   // last
);

	`include "tsp_nearest_neighbour_tour_macros.svh"

	// longest tour handled: bounded by the matrix and by the result limit
	localparam int NMAX  = (MAX_CITIES < tnn_pkg::RESULT_LIMIT) ? MAX_CITIES
	                                                            : tnn_pkg::RESULT_LIMIT;
	localparam int PW    = $clog2(NMAX);
	localparam int DEPTH = MAX_CITIES * MAX_CITIES;
	localparam int AW    = $clog2(DEPTH);
	// adder wide enough for cost plus one distance before saturation
	localparam int SW    = ((WEIGHT_BITS > tnn_pkg::COST_W) ? WEIGHT_BITS
	                                                        : tnn_pkg::COST_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE,   // take matrix beats
		S_START,  // seed a trial tour from start_q
		S_SCAN,   // issue one read per candidate city
		S_SWAIT,  // last candidate reaches the compare unit
		S_MOVE,   // step to the nearest unvisited city
		S_CLOSE,  // read the leg back to the start
		S_CADD,   // add the closing leg
		S_JUDGE,  // keep the trial if strictly cheaper, or always with a single start
		S_EMIT    // stream the kept tour
	} state_t;

	// input beat fields
	logic [tnn_pkg::CITY_W-1:0] in_row;
	logic [tnn_pkg::CITY_W-1:0] in_col;
	logic [15:0]                in_weight;
	logic                       in_beat;

	assign in_row    = s_axis_tdata[3:0];
	assign in_col    = s_axis_tdata[7:4];
	assign in_weight = s_axis_tdata[23:8];
	assign in_beat   = s_axis_tvalid && s_axis_tready;

	// config registers
	logic [tnn_pkg::COUNT_W-1:0] city_count_q;
	logic [tnn_pkg::CITY_W-1:0]  start_city_q;
	logic                        all_starts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= tnn_pkg::COUNT_W'(16);
			start_city_q <= '0;
			all_starts_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tnn_pkg::REG_CITY_COUNT: city_count_q <= cfg_data;
				tnn_pkg::REG_START_CITY: start_city_q <= cfg_data[tnn_pkg::CITY_W-1:0];
				tnn_pkg::REG_ALL_STARTS: all_starts_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t                      state_q;
	logic [tnn_pkg::COUNT_W-1:0] n_q;        // cities in this build
	logic [tnn_pkg::CITY_W-1:0]  start_q;    // current start city
	logic [tnn_pkg::CITY_W-1:0]  here_q;     // city the tour stands on
	logic [tnn_pkg::CITY_W-1:0]  c_q;        // scan index
	logic [tnn_pkg::POS_W-1:0]   step_q;     // tour slot being filled
	logic [tnn_pkg::POS_W-1:0]   pos_q;      // next slot to emit
	logic [NMAX-1:0]             visited_q;
	logic [tnn_pkg::COST_W-1:0]  trial_cost_q;
	logic [tnn_pkg::BEST_W-1:0]  best_cost_q;
	logic                        wsel_q;     // tour buffer being built
	logic                        best_sel_q; // tour buffer holding the best
	tnn_pkg::cand_t              cand_s1;

	// output register
	logic                        out_vld_q;
	logic                        out_last_q;
	logic [tnn_pkg::POS_W-1:0]   out_pos_q;
	logic [tnn_pkg::CITY_W-1:0]  out_city_q;

	// two tour buffers; the better one is kept by flipping selects, no copy
	logic [tnn_pkg::CITY_W-1:0]  tour_q [2][NMAX];

	// memory and compare unit hookup
	logic                        mem_wr_en;
	logic [AW-1:0]               mem_wr_addr;
	logic [AW-1:0]               mem_rd_addr;
	logic [tnn_pkg::CITY_W-1:0]  rd_city;
	logic [WEIGHT_BITS-1:0]      rd_data;
	logic                        min_clr;
	logic [tnn_pkg::CITY_W-1:0]  best_city;
	logic [WEIGHT_BITS-1:0]      best_dist;

	// shared saturating adder: scan leg in S_MOVE, closing leg in S_CADD
	logic [WEIGHT_BITS-1:0]      add_d;
	logic [SW-1:0]               add_sum;
	logic [tnn_pkg::COST_W-1:0]  add_sat;

	// build setup from the live config
	logic [tnn_pkg::COUNT_W-1:0] n_eff;
	logic                        build_ok;

	assign n_eff = (city_count_q > tnn_pkg::COUNT_W'(NMAX)) ? tnn_pkg::COUNT_W'(NMAX)
	                                                        : city_count_q;
	assign build_ok = (n_eff >= tnn_pkg::COUNT_W'(2)) &&
	                  (all_starts_q || ({1'b0, start_city_q} < n_eff));

	// entries outside the matrix are dropped
	assign mem_wr_en   = in_beat && (int'(in_row) < MAX_CITIES) && (int'(in_col) < MAX_CITIES);
	assign mem_wr_addr = AW'(int'(in_row) * MAX_CITIES + int'(in_col));
	assign rd_city     = (state_q == S_CLOSE) ? start_q : c_q;
	assign mem_rd_addr = AW'(int'(here_q) * MAX_CITIES + int'(rd_city));

	assign min_clr = (state_q == S_START) || (state_q == S_MOVE);

	assign add_d   = (state_q == S_CADD) ? rd_data : best_dist;
	assign add_sum = SW'(trial_cost_q) + SW'(add_d);
	assign add_sat = (add_sum > SW'(tnn_pkg::COST_MAX)) ? tnn_pkg::COST_MAX
	                                                    : add_sum[tnn_pkg::COST_W-1:0];

	tnn_dist_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (WEIGHT_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (WEIGHT_BITS'(in_weight)),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	tnn_min_unit #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (min_clr),
		.cand      (cand_s1),
		.cand_dist (rd_data),
		.best_city (best_city),
		.best_dist (best_dist)
	);

	// tour buffer writes
	always_ff @(posedge clk) begin
		if (state_q == S_START) begin
			tour_q[wsel_q][0] <= start_q;
		end else if (state_q == S_MOVE) begin
			tour_q[wsel_q][step_q[PW-1:0]] <= best_city;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			n_q          <= '0;
			start_q      <= '0;
			here_q       <= '0;
			c_q          <= '0;
			step_q       <= '0;
			pos_q        <= '0;
			visited_q    <= '0;
			trial_cost_q <= '0;
			best_cost_q  <= '1;
			wsel_q       <= 1'b0;
			best_sel_q   <= 1'b0;
			cand_s1      <= '0;
			out_vld_q    <= 1'b0;
			out_last_q   <= 1'b0;
			out_pos_q    <= '0;
			out_city_q   <= '0;
		end else begin
			// candidate is registered so it lines up with the registered read data
			cand_s1.vld  <= (state_q == S_SCAN);
			cand_s1.skip <= visited_q[c_q[PW-1:0]];
			cand_s1.city <= c_q;

			unique case (state_q)
				S_IDLE: begin
					if (in_beat && s_axis_tlast && build_ok) begin
						n_q         <= n_eff;
						start_q     <= all_starts_q ? '0 : start_city_q;
						best_cost_q <= '1;
						state_q     <= S_START;
					end
				end
				S_START: begin
					// only the start city is visited
					visited_q    <= NMAX'(1) << start_q[PW-1:0];
					here_q       <= start_q;
					trial_cost_q <= '0;
					step_q       <= tnn_pkg::POS_W'(1);
					c_q          <= '0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					if ({1'b0, c_q} == n_q - tnn_pkg::COUNT_W'(1)) begin
						state_q <= S_SWAIT;
					end else begin
						c_q <= c_q + tnn_pkg::CITY_W'(1);
					end
				end
				S_SWAIT: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					visited_q[best_city[PW-1:0]] <= 1'b1;
					trial_cost_q                 <= add_sat;
					here_q                       <= best_city;
					c_q                          <= '0;
					if ({1'b0, step_q} == n_q - tnn_pkg::COUNT_W'(1)) begin
						state_q <= S_CLOSE;
					end else begin
						step_q  <= step_q + tnn_pkg::POS_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_CLOSE: begin
					state_q <= S_CADD;
				end
				S_CADD: begin
					trial_cost_q <= add_sat;
					state_q      <= S_JUDGE;
				end
				S_JUDGE: begin
					if (!all_starts_q || ({1'b0, trial_cost_q} < best_cost_q)) begin
						best_cost_q <= {1'b0, trial_cost_q};
						best_sel_q  <= wsel_q;
						wsel_q      <= ~wsel_q;
					end
					if (all_starts_q && ({1'b0, start_q} != n_q - tnn_pkg::COUNT_W'(1))) begin
						start_q <= start_q + tnn_pkg::CITY_W'(1);
						state_q <= S_START;
					end else begin
						pos_q     <= '0;
						out_vld_q <= 1'b0;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_vld_q || m_axis_tready) begin
						if (out_vld_q && out_last_q) begin
							out_vld_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							out_vld_q  <= 1'b1;
							out_pos_q  <= pos_q;
							out_city_q <= tour_q[best_sel_q][pos_q[PW-1:0]];
							out_last_q <= ({1'b0, pos_q} == n_q - tnn_pkg::COUNT_W'(1));
							pos_q      <= pos_q + tnn_pkg::POS_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0, best_cost_q[tnn_pkg::COST_W-1:0], out_city_q, out_pos_q};

	// intake and emission never overlap
	`TNN_ASSERT_IMP(a_no_intake_during_emit, m_axis_tvalid, !s_axis_tready)
	// the final beat ends the tour
	`TNN_ASSERT_NXT(a_last_closes_tour, m_axis_tvalid && m_axis_tready && m_axis_tlast,
		!m_axis_tvalid)
	// positions run back to back
	`TNN_ASSERT_NXT(a_position_steps, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
	// no position beyond the city count
	`TNN_ASSERT_IMP(a_position_in_range, m_axis_tvalid, {1'b0, m_axis_tdata[3:0]} < n_q)

endmodule

FILE: tb/tb_tsp_nearest_neighbour_tour.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tsp_nearest_neighbour_tour
// Streams distance-matrix beats into the tour builder and checks every tour
// beat against a greedy nearest-neighbour predictor kept in the bench. A
// directed opener covers ties, weight extremes, too few cities, a bad start
// and start ignored in all-starts mode. Random phases follow under changing
// settings. The sender and the receiver idle at random, but for one steady phase.
// ----------------------------------------------------------------------------
module tb_tsp_nearest_neighbour_tour;

	localparam int MAX_CITIES = 16;
	localparam int BEST_RESET = 2097151;   // 21-bit all ones

	// one matrix beat as the sender sees it
	typedef struct {
		logic [tnn_pkg::CITY_W-1:0] row;
		logic [tnn_pkg::CITY_W-1:0] col;
		logic [15:0]                weight;
		logic                       done;
	} matrix_entry_t;

	// one tour beat as the receiver should see it
	typedef struct {
		logic [tnn_pkg::POS_W-1:0]  position;
		logic [tnn_pkg::CITY_W-1:0] city;
		logic [tnn_pkg::COST_W-1:0] cost;
		logic                       last;
	} tour_stop_t;

	logic                           clk;
	logic                           arst_n        = 1'b0;
	logic                           cfg_wr_en     = 1'b0;
	logic [tnn_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [tnn_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [23:0]                    s_axis_tdata  = '0;   // row[3:0] col[7:4] weight[23:8]
	logic                           s_axis_tlast  = 1'b0; // load_done
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [31:0]                    m_axis_tdata;  // position[3:0] city[7:4] tour_cost[27:8]
	logic                           m_axis_tlast;  // last

	tsp_nearest_neighbour_tour u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------
	matrix_entry_t entry_q [$];   // beats not yet driven
	tour_stop_t    tour_q [$];    // tour beats still owed by the block
	matrix_entry_t held_entry;    // beat on the bus right now
	int            entries_open = 0; // queued or on the bus, not yet taken
	int            entries_queued = 0;
	int            fail_count = 0;
	bit            steady = 1'b0;  // no idling on either side while set
	bit            loaded [MAX_CITIES][MAX_CITIES]; // entry queued at least once

	// settings as the block holds them
	logic [tnn_pkg::COUNT_W-1:0] cfg_n     = 5'd16;
	logic [tnn_pkg::CITY_W-1:0]  cfg_start = '0;
	logic                        cfg_all   = 1'b0;

	// predictor state
	logic [15:0]                 dist_mem  [MAX_CITIES][MAX_CITIES];
	logic [tnn_pkg::CITY_W-1:0]  walk_path [MAX_CITIES];
	logic [tnn_pkg::CITY_W-1:0]  best_path [MAX_CITIES];
	int                          walk_cost;
	int                          best_cost;

	function automatic int capped_sum(input int a, input int b);
		int s;
		s = a + b;
		return (s > int'(tnn_pkg::COST_MAX)) ? int'(tnn_pkg::COST_MAX) : s;
	endfunction

	// greedy walk from one start over the first n cities
	function automatic void walk_from(input int n, input int start);
		logic [MAX_CITIES-1:0] visited;
		int here, pick, pick_d, d, sum;
		visited = '0;
		visited[start] = 1'b1;
		here = start;
		walk_path[0] = tnn_pkg::CITY_W'(start);
		sum = 0;
		for (int step = 1; step < n; step++) begin
			pick = -1;
			pick_d = 0;
			for (int c = 0; c < n; c++) begin
				if (!visited[c]) begin
					d = dist_mem[here][c];
					// strict less: ties keep the lower index
					if (pick < 0 || d < pick_d) begin
						pick = c;
						pick_d = d;
					end
				end
			end
			walk_path[step] = tnn_pkg::CITY_W'(pick);
			visited[pick] = 1'b1;
			sum = capped_sum(sum, pick_d);
			here = pick;
		end
		walk_cost = capped_sum(sum, dist_mem[here][start]);
	endfunction

	// store the entry, build the tour if asked, queue the owed beats
	function automatic void predict_tour(input matrix_entry_t e);
		int n;
		tour_stop_t stop;
		dist_mem[e.row][e.col] = e.weight;
		if (!e.done)
			return;
		n = cfg_n;
		if (n > MAX_CITIES)
			n = MAX_CITIES;
		if (n < 2)
			return;
		if (cfg_all) begin
			best_cost = BEST_RESET;
			for (int s = 0; s < n; s++) begin
				walk_from(n, s);
				if (walk_cost < best_cost) begin
					best_cost = walk_cost;
					best_path = walk_path;
				end
			end
		end else begin
			if (cfg_start >= n)
				return;
			walk_from(n, cfg_start);
			best_cost = walk_cost;
			best_path = walk_path;
		end
		for (int k = 0; k < n; k++) begin
			stop.position = tnn_pkg::POS_W'(k);
			stop.city     = best_path[k];
			stop.cost     = tnn_pkg::COST_W'(best_cost);
			stop.last     = (k == n - 1);
			tour_q.push_back(stop);
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// driver: one beat per handshake, random gaps
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_tour(held_entry);
				entries_open--;
			end
			// bus free for a new beat
			if (!s_axis_tvalid || s_axis_tready) begin
				if (entry_q.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
					held_entry = entry_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {held_entry.weight, held_entry.col, held_entry.row};
					s_axis_tlast  <= held_entry.done;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random back-pressure, check each tour beat in order
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		tour_stop_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (tour_q.size() == 0) begin
					$error("tour beat with nothing owed: tdata %h last %b",
						m_axis_tdata, m_axis_tlast);
					fail_count++;
				end else begin
					want = tour_q.pop_front();
					check_field("position",  want.position, m_axis_tdata[3:0]);
					check_field("city",      want.city,     m_axis_tdata[7:4]);
					check_field("tour_cost", want.cost,     m_axis_tdata[27:8]);
					check_field("last",      want.last,     m_axis_tlast);
				end
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));           // ties likely
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int used_cities();
		return (cfg_n > MAX_CITIES) ? MAX_CITIES : int'(cfg_n);
	endfunction

	task automatic push_entry(input int r, input int c, input logic [15:0] w, input bit done);
		matrix_entry_t e;
		e.row    = tnn_pkg::CITY_W'(r);
		e.col    = tnn_pkg::CITY_W'(c);
		e.weight = w;
		e.done   = done;
		loaded[r][c] = 1'b1;
		entries_open++;
		entries_queued++;
		entry_q.push_back(e);
	endtask

	// build beat; first fills any entry of the used square never loaded,
	// so the walk never reads an empty slot
	task automatic push_build(input int r, input int c, input logic [15:0] w);
		int n;
		n = used_cities();
		if (n >= 2) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					if (!loaded[i][j])
						push_entry(i, j, rand_weight(), 1'b0);
		end
		push_entry(r, c, w, 1'b1);
	endtask

	// all beats taken, all tour beats in, then the longest build time
	task automatic settle();
		int n, starts;
		n = used_cities();
		if (n < 2)
			n = 2;
		starts = cfg_all ? n : 1;
		while (entries_open != 0)
			@(posedge clk);
		while (tour_q.size() != 0)
			@(posedge clk);
		repeat (starts * (4 + (n - 1) * (n + 2)) + n + 16)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [tnn_pkg::CFG_IDX_W-1:0] idx,
		input logic [tnn_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			tnn_pkg::REG_CITY_COUNT: cfg_n     = val;
			tnn_pkg::REG_START_CITY: cfg_start = val[tnn_pkg::CITY_W-1:0];
			tnn_pkg::REG_ALL_STARTS: cfg_all   = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int n, input int start, input bit all);
		settle();
		write_reg(tnn_pkg::REG_CITY_COUNT, tnn_pkg::CFG_DATA_W'(n));
		write_reg(tnn_pkg::REG_START_CITY, tnn_pkg::CFG_DATA_W'(start));
		write_reg(tnn_pkg::REG_ALL_STARTS, tnn_pkg::CFG_DATA_W'(all));
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		int n, phase, phase_end, run_goal;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero 3x3: every step is a tie, lower index wins
		apply_setting(3, 0, 0);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				push_entry(r, c, 16'h0000, (r == 2 && c == 2));
		// top weight on one leg, rebuild
		push_entry(0, 1, 16'hFFFF, 1'b1);
		// plain loads, no build, corner indexes
		push_entry(15, 15, 16'hFFFF, 1'b0);
		push_entry(15, 0, 16'h0000, 1'b0);
		push_entry(0, 15, 16'hA5A5, 1'b0);
		// best of all starts
		apply_setting(3, 0, 1);
		push_entry(1, 2, 16'h8000, 1'b1);
		// start register out of range is ignored when all starts are tried
		apply_setting(3, 15, 1);
		push_entry(2, 0, 16'h0001, 1'b1);
		// single start at or past the count: nothing comes out
		apply_setting(3, 3, 0);
		push_build(1, 0, 16'h0007);
		apply_setting(3, 15, 0);
		push_build(2, 1, 16'h5A5A);
		// too few cities
		apply_setting(1, 0, 0);
		push_entry(0, 0, 16'h1234, 1'b1);
		apply_setting(0, 0, 1);
		push_entry(1, 1, 16'hFFFF, 1'b1);
		// smallest real tour
		apply_setting(2, 1, 0);
		push_build(1, 0, 16'hFFFF);

		// random phases, mostly small city counts, up to about 160 beats in all
		run_goal = 160;
		phase = 0;
		while (entries_queued < run_goal) begin
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 1);
				9: n = $urandom_range(7, 9);
				default: n = $urandom_range(2, 6);
			endcase
			apply_setting(n,
				($urandom_range(0, 4) == 0 || n == 0) ? $urandom_range(0, 15)
					: $urandom_range(0, n - 1),
				$urandom_range(0, 1));
			steady = (phase == 1);
			phase_end = entries_queued + 20;
			while (entries_queued < phase_end) begin
				if (n >= 2 && $urandom_range(0, 9) < 7) begin
					// rewrite part of the used square, then build
					repeat ($urandom_range(1, (n * n > 8) ? 8 : n * n))
						push_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
							rand_weight(), 1'b0);
					push_build($urandom_range(0, n - 1), $urandom_range(0, n - 1),
						rand_weight());
				end else if ($urandom_range(0, 9) == 0) begin
					push_build($urandom_range(0, 15), $urandom_range(0, 15), rand_weight());
				end else begin
					push_entry($urandom_range(0, 15), $urandom_range(0, 15),
						rand_weight(), 1'b0);
				end
			end
			phase++;
		end
		steady = 1'b0;

		settle();
		if (fail_count == 0 && tour_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (tour_q.size() != 0)
				$error("%0d tour beats never arrived", tour_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
